// File: hdl/refcounted_page_allocator_assert.svh
// Assertion macros used by the checker file of the page allocator.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rpa_pkg.sv
package rpa_pkg;

    // Default sizing of the allocator.
    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_REF_BITS   = 16;

    // Fixed field widths of the ports.
    localparam int ADDR_W      = 64;
    localparam int CFG_CNT_W   = 13;
    localparam int REF_OUT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd2;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0]    MEM_BASE_RST   = 64'h0000_0000_8000_0000;
    localparam logic [CFG_CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;
    localparam logic [CFG_CNT_W-1:0] RESERVED_RST   = 13'd0;

    // Operation codes.
    typedef enum logic [1:0] {
        FN_ALLOC    = 2'd0,
        FN_ADD_REF  = 2'd1,
        FN_DROP_REF = 2'd2,
        FN_INIT     = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NONE_FREE  = 3'd1,
        ST_BAD_ADDR   = 3'd2,
        ST_UNDERFLOW  = 3'd3,
        ST_SATURATED  = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_INIT = 2'd2,
        S_EXEC = 2'd3
    } t_state;

endpackage

// File: hdl/rpa_if.sv
// Request channel: one operation per item.
interface rpa_req_if;
    import rpa_pkg::*;

    logic              valid;
    logic              ready;
    t_func             func;
    logic [ADDR_W-1:0] page_address;

    modport source (output valid, output func, output page_address, input ready);
    modport sink   (input valid, input func, input page_address, output ready);
endinterface

// Response channel: one result per operation.
interface rpa_rsp_if;
    import rpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    result_address;
    t_status              status;
    logic [CFG_CNT_W-1:0] free_pages;
    logic [REF_OUT_W-1:0] ref_after;

    modport source (output valid, output result_address, output status,
                    output free_pages, output ref_after, input ready);
    modport sink   (input valid, input result_address, input status,
                    input free_pages, input ref_after, output ready);
endinterface

// File: hdl/refcounted_page_allocator.sv
// Allocate, add reference and drop reference: a memory read in S_READ, then write-back and
// output load in S_EXEC; a new item is taken only once the sequencer is back in S_IDLE.
// Initialize writes one count a cycle, and a stack entry for each free page, in S_INIT,
// then loads its result in S_EXEC. A stalled result holds off the next item.
// Reset (synchronous, active low) empties the free stack, clears the initialized flag and
// restores the configuration; the memories hold no valid state until initialize.
module refcounted_page_allocator #(
    parameter int MAX_PAGES  = rpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = rpa_pkg::DEF_PAGE_BYTES,
    parameter int REF_BITS   = rpa_pkg::DEF_REF_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rpa_req_if.sink                         i_req,
    rpa_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int PB_W   = $clog2(PAGE_BYTES);
    localparam int CMP_W  = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
    localparam int REFX_W = (REF_BITS > REF_OUT_W) ? REF_BITS : REF_OUT_W;

    localparam logic [CMP_W-1:0]    MAXP_X    = CMP_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0]    MAXP_CNT  = CNT_W'(MAX_PAGES);
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(MAX_PAGES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX   = '1;
    localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);

    // Configuration registers.
    logic [ADDR_W-1:0]    r_mem_base;
    logic [CFG_CNT_W-1:0] r_page_count;
    logic [CFG_CNT_W-1:0] r_reserved;

    // Control state.
    t_state            r_state, n_state;
    logic              r_init;
    logic [CNT_W-1:0]  r_free_top, n_free_top;
    logic [IDX_W-1:0]  r_sweep;

    // Item held while it is worked on.
    t_func             r_func;
    logic [ADDR_W-1:0] r_addr;
    logic              r_bad;
    logic [IDX_W-1:0]  r_idx;

    // Output register.
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_addr;
    t_status              r_out_status;
    logic [CFG_CNT_W-1:0] r_out_free;
    logic [REF_OUT_W-1:0] r_out_ref;

    // Derived configuration.
    logic [CMP_W-1:0] pc_x, eff_x, rs_x, sweep_x;
    logic [CNT_W-1:0] eff_count;

    // Decoder and memory ports.
    logic              dec_bad;
    logic [IDX_W-1:0]  dec_idx;
    logic              cnt_we, cnt_re;
    logic [IDX_W-1:0]  cnt_waddr, cnt_raddr;
    logic [REF_BITS-1:0] cnt_wdata, cnt_rdata;
    logic              stk_we, stk_re;
    logic [IDX_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // Handshake and result values.
    logic                accept, out_free, exec_fire, sweep_last;
    logic                sweep_resv, sweep_free;
    logic [CNT_W-1:0]    ftop_m1;
    logic [ADDR_W-1:0]   n_res_addr;
    t_status             n_status;
    logic [REF_BITS-1:0] n_ref;
    logic [REFX_W-1:0]   n_ref_x;
    logic [CMP_W-1:0]    n_free_x;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign exec_fire   = (r_state == S_EXEC) && out_free;
    assign sweep_last  = (r_sweep == LAST_IDX);
    assign ftop_m1     = r_free_top - CNT_W'(1);

    // Page count clamped to the capacity; reserved pages clamped to that.
    assign pc_x       = CMP_W'(r_page_count);
    assign eff_x      = (pc_x > MAXP_X) ? MAXP_X : pc_x;
    assign eff_count  = eff_x[CNT_W-1:0];
    assign rs_x       = CMP_W'(r_reserved);
    assign sweep_x    = CMP_W'(r_sweep);
    assign sweep_resv = (sweep_x < rs_x) && (sweep_x < eff_x);
    assign sweep_free = !sweep_resv && (sweep_x < eff_x);

    rpa_addr_dec #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_addr_dec (
        .i_addr      (r_addr),
        .i_base      (r_mem_base),
        .i_eff_count (eff_count),
        .o_bad       (dec_bad),
        .o_idx       (dec_idx)
    );

    // Reference counts, one entry per page.
    rpa_ram #(
        .DEPTH (MAX_PAGES),
        .WIDTH (REF_BITS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Free page stack, filled from the bottom.
    rpa_ram #(
        .DEPTH (MAX_PAGES),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.func == FN_INIT) ? S_INIT : S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_INIT: begin
                if (sweep_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory accesses, stack pointer and result values for each state.
    // Only one item is in flight, so a write-back always lands before the next read.
    always_comb begin
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_waddr  = r_idx;
        cnt_raddr  = dec_idx;
        cnt_wdata  = REF_ONE;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_waddr  = r_free_top[IDX_W-1:0];
        stk_raddr  = ftop_m1[IDX_W-1:0];
        stk_wdata  = r_idx;
        n_free_top = r_free_top;
        n_res_addr = r_addr;
        n_status   = ST_OK;
        n_ref      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.func == FN_INIT)) begin
                    n_free_top = '0;
                end
            end
            S_READ: begin
                cnt_re = 1'b1;
                stk_re = 1'b1;
            end
            S_INIT: begin
                // Reserved pages get one reference, free pages go on the stack.
                cnt_we    = 1'b1;
                cnt_waddr = r_sweep;
                cnt_wdata = sweep_resv ? REF_ONE : '0;
                if (sweep_free) begin
                    stk_we     = 1'b1;
                    stk_wdata  = r_sweep;
                    n_free_top = r_free_top + CNT_W'(1);
                end
            end
            S_EXEC: begin
                unique case (r_func)
                    FN_INIT: begin
                        n_status = ST_OK;
                    end
                    FN_ALLOC: begin
                        if (!r_init || (r_free_top == '0)) begin
                            n_status = ST_NONE_FREE;
                        end else begin
                            cnt_we     = exec_fire;
                            cnt_waddr  = stk_rdata;
                            cnt_wdata  = REF_ONE;
                            n_free_top = ftop_m1;
                            n_res_addr = r_mem_base + (ADDR_W'(stk_rdata) << PB_W);
                            n_ref      = REF_ONE;
                        end
                    end
                    FN_ADD_REF: begin
                        if (!r_init || r_bad || (cnt_rdata == '0)) begin
                            n_status = ST_BAD_ADDR;
                        end else if (cnt_rdata == REF_MAX) begin
                            n_status = ST_SATURATED;
                            n_ref    = cnt_rdata;
                        end else begin
                            cnt_we    = exec_fire;
                            cnt_wdata = cnt_rdata + REF_ONE;
                            n_ref     = cnt_rdata + REF_ONE;
                        end
                    end
                    FN_DROP_REF: begin
                        if (!r_init || r_bad) begin
                            n_status = ST_BAD_ADDR;
                        end else if (cnt_rdata == '0) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            cnt_we    = exec_fire;
                            cnt_wdata = cnt_rdata - REF_ONE;
                            n_ref     = cnt_rdata - REF_ONE;
                            // Last reference gone: the page returns to the stack if it has room.
                            if ((cnt_rdata == REF_ONE) && (r_free_top < MAXP_CNT)) begin
                                stk_we     = exec_fire;
                                n_free_top = r_free_top + CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
                if (!exec_fire) begin
                    n_free_top = r_free_top;
                end
            end
            default: begin
                n_free_top = r_free_top;
            end
        endcase
    end

    assign n_ref_x  = REFX_W'(n_ref);
    assign n_free_x = CMP_W'(n_free_top);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base   <= MEM_BASE_RST;
            r_page_count <= PAGE_COUNT_RST;
            r_reserved   <= RESERVED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEM_BASE:   r_mem_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_RESERVED:   r_reserved   <= i_cfg_data[CFG_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b0;
            r_free_top  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_top <= n_free_top;
            if ((r_state == S_INIT) && sweep_last) begin
                r_init <= 1'b1;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item registers, sweep counter and decoded address.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_addr  <= i_req.page_address;
            r_sweep <= '0;
        end else if (r_state == S_INIT) begin
            r_sweep <= r_sweep + IDX_W'(1);
        end
        if (r_state == S_READ) begin
            r_bad <= dec_bad;
            r_idx <= dec_idx;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_addr   <= n_res_addr;
            r_out_status <= n_status;
            r_out_free   <= n_free_x[CFG_CNT_W-1:0];
            r_out_ref    <= n_ref_x[REF_OUT_W-1:0];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.free_pages     = r_out_free;
    assign o_rsp.ref_after      = r_out_ref;

endmodule

// File: hdl/rpa_ram.sv
module rpa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rpa_addr_dec.sv
module rpa_addr_dec #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic [rpa_pkg::ADDR_W-1:0]         i_addr,
    input  logic [rpa_pkg::ADDR_W-1:0]         i_base,
    input  logic [$clog2(MAX_PAGES + 1)-1:0]   i_eff_count,
    output logic                               o_bad,
    output logic [$clog2(MAX_PAGES)-1:0]       o_idx
);
    import rpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int PB_W  = $clog2(PAGE_BYTES);
    localparam int PN_W  = ADDR_W - PB_W;

    logic              borrow;
    logic [ADDR_W-1:0] offset;
    logic [PN_W-1:0]   frame_no;
    logic [PN_W-1:0]   eff_ext;

    // Offset from the base; the borrow flags an address below the base.
    assign {borrow, offset} = {1'b0, i_addr} - {1'b0, i_base};
    assign frame_no         = offset[ADDR_W-1:PB_W];
    assign eff_ext          = PN_W'(i_eff_count);

    // Below the base, not page aligned, or past the managed range.
    assign o_bad = borrow | (|offset[PB_W-1:0]) | (frame_no >= eff_ext);
    assign o_idx = frame_no[IDX_W-1:0];

endmodule

// File: hdl/rpa_checker.sv
`include "refcounted_page_allocator_assert.svh"

module rpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input rpa_pkg::t_status                i_rsp_status,
    input logic [rpa_pkg::CFG_CNT_W-1:0]   i_rsp_free_pages,
    input logic [rpa_pkg::REF_OUT_W-1:0]   i_rsp_ref_after
);
    import rpa_pkg::*;

    // A stalled result stays offered.
    `RPA_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result withdrawn while stalled")

    // Items are worked one at a time, so no item is taken right after another.
    `RPA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "item accepted while one is in work")

    // Failures that leave no page concerned report a zero count.
    `RPA_ASSERT_IMP(a_fail_ref_zero, i_clk, i_rst_n, i_rsp_valid && ((i_rsp_status == ST_NONE_FREE) || (i_rsp_status == ST_BAD_ADDR) || (i_rsp_status == ST_UNDERFLOW)), i_rsp_ref_after == '0, "failed operation reports a count")

    // An empty stack is the only reason for none free.
    `RPA_ASSERT_IMP(a_none_free_empty, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == ST_NONE_FREE), i_rsp_free_pages == '0, "none free with pages on the stack")

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_free_pages (o_rsp.free_pages),
    .i_rsp_ref_after  (o_rsp.ref_after)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rpa_pkg::*;

    localparam int MAX_PAGES   = DEF_MAX_PAGES;
    localparam int IDX_W       = $clog2(DEF_MAX_PAGES);
    localparam int PAGE_SHIFT  = $clog2(DEF_PAGE_BYTES);
    localparam int REF_MAX     = (1 << DEF_REF_BITS) - 1;
    localparam int HALF_PERIOD = 10;
    localparam int QUIET_LIMIT = 40000;
    localparam int MAX_REPORTS = 20;
    localparam int HELD_DEPTH  = 64;
    localparam int CLIMB_OPS   = 30;

    // Index that decodes to no register at all.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_func             func;
        logic [ADDR_W-1:0] page_address;
    } t_page_op;

    typedef struct packed {
        logic [ADDR_W-1:0]    result_address;
        t_status              status;
        logic [CFG_CNT_W-1:0] free_pages;
        logic [REF_OUT_W-1:0] ref_after;
    } t_page_result;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rpa_req_if req_if();
    rpa_rsp_if rsp_if();

    refcounted_page_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the allocator state and its registers.
    logic [ADDR_W-1:0]        base_r;
    logic [CFG_CNT_W-1:0]     pcnt_r;
    logic [CFG_CNT_W-1:0]     resv_r;
    logic [DEF_REF_BITS-1:0]  ref_count [MAX_PAGES];
    logic [IDX_W-1:0]         free_stack [MAX_PAGES];
    logic [CFG_CNT_W-1:0]     free_top;
    bit                       pages_ready;
    logic [IDX_W-1:0]         held_pages[$];

    t_page_op     op_queue[$];
    t_page_result pending_results[$];
    t_idle_mode   idle_mode;
    bit           req_taken;
    int           err_cnt;
    int           quiet_cycles;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic logic [CFG_CNT_W-1:0] managed_pages();
        return (pcnt_r > MAX_PAGES) ? CFG_CNT_W'(MAX_PAGES) : pcnt_r;
    endfunction

    function automatic logic [ADDR_W-1:0] page_at(logic [ADDR_W-1:0] base, int unsigned idx);
        return base + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

    function automatic bit roll_idle(bit sender);
        int unsigned pct;
        case (idle_mode)
            IDLE_SEND: pct = sender ? 71 : 0;
            IDLE_RECV: pct = sender ? 0 : 71;
            IDLE_BOTH: pct = 38;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // Applies one operation to the shadow state and returns what the block should answer.
    function automatic t_page_result compute_page_result(t_func fn, logic [ADDR_W-1:0] addr);
        t_page_result      res;
        logic [ADDR_W-1:0] offset;
        logic [CFG_CNT_W-1:0] limit;
        logic [CFG_CNT_W-1:0] kept;
        logic [IDX_W-1:0]  idx;
        bit                hit;
        res.result_address = addr;
        res.status         = ST_OK;
        res.ref_after      = '0;
        limit  = managed_pages();
        offset = addr - base_r;
        hit    = pages_ready && (addr >= base_r) && (offset[PAGE_SHIFT-1:0] == '0) &&
                 ((offset >> PAGE_SHIFT) < ADDR_W'(limit));
        idx    = offset[PAGE_SHIFT +: IDX_W];
        case (fn)
            FN_INIT: begin
                kept = (resv_r > limit) ? limit : resv_r;
                free_top = '0;
                held_pages.delete();
                for (int i = 0; i < MAX_PAGES; i++) begin
                    ref_count[i] = (i < kept) ? DEF_REF_BITS'(1) : '0;
                    if (i >= kept && i < limit) begin
                        free_stack[free_top] = IDX_W'(i);
                        free_top++;
                    end
                end
                pages_ready = 1'b1;
            end
            FN_ALLOC: begin
                if (!pages_ready || free_top == 0) begin
                    res.status = ST_NONE_FREE;
                end else begin
                    free_top--;
                    idx = free_stack[free_top];
                    ref_count[idx] = DEF_REF_BITS'(1);
                    res.result_address = page_at(base_r, idx);
                    res.ref_after = REF_OUT_W'(1);
                    held_pages.push_back(idx);
                    if (held_pages.size() > HELD_DEPTH)
                        void'(held_pages.pop_front());
                end
            end
            FN_ADD_REF: begin
                // A free page cannot gain a reference; a full count stays put.
                if (!hit || ref_count[idx] == 0) begin
                    res.status = ST_BAD_ADDR;
                end else if (ref_count[idx] == REF_MAX) begin
                    res.status = ST_SATURATED;
                    res.ref_after = ref_count[idx];
                end else begin
                    ref_count[idx]++;
                    res.ref_after = ref_count[idx];
                end
            end
            default: begin
                // The last reference returns the page to the free stack if it has room.
                if (!hit) begin
                    res.status = ST_BAD_ADDR;
                end else if (ref_count[idx] == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    ref_count[idx]--;
                    res.ref_after = ref_count[idx];
                    if (ref_count[idx] == 0 && free_top < MAX_PAGES) begin
                        free_stack[free_top] = idx;
                        free_top++;
                    end
                end
            end
        endcase
        res.free_pages = free_top;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (err_cnt < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        err_cnt++;
    endtask

    // Requests: hold an item until it is taken, then fetch the next one.
    always @(negedge i_clk) begin
        t_page_op op;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (op_queue.size() != 0 && !roll_idle(1'b1)) begin
                op = op_queue.pop_front();
                req_if.valid        <= 1'b1;
                req_if.func         <= op.func;
                req_if.page_address <= op.page_address;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= i_rst_n && !roll_idle(1'b0);
    end

    // Prediction on every accepted request, checking on every accepted result.
    always @(posedge i_clk) begin
        t_page_result want;
        if (!i_rst_n) begin
            base_r       = MEM_BASE_RST;
            pcnt_r       = PAGE_COUNT_RST;
            resv_r       = RESERVED_RST;
            free_top     = '0;
            pages_ready  = 1'b0;
            held_pages.delete();
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEM_BASE:   base_r = i_cfg_data;
                    CFG_PAGE_COUNT: pcnt_r = i_cfg_data[CFG_CNT_W-1:0];
                    CFG_RESERVED:   resv_r = i_cfg_data[CFG_CNT_W-1:0];
                    default:        ;
                endcase
            end
            if (req_if.valid && req_if.ready)
                pending_results.push_back(compute_page_result(req_if.func, req_if.page_address));
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got %h status %0d",
                                 $time, rsp_if.result_address, rsp_if.status);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.result_address !== want.result_address)
                        report_mismatch("result_address", want.result_address,
                                        rsp_if.result_address);
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp_if.status));
                    if (rsp_if.free_pages !== want.free_pages)
                        report_mismatch("free_pages", ADDR_W'(want.free_pages),
                                        ADDR_W'(rsp_if.free_pages));
                    if (rsp_if.ref_after !== want.ref_after)
                        report_mismatch("ref_after", ADDR_W'(want.ref_after),
                                        ADDR_W'(rsp_if.ref_after));
                end
            end
            // Watchdog on cycles without any handshake.
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_op(t_func fn, logic [ADDR_W-1:0] addr);
        op_queue.push_back('{func: fn, page_address: addr});
    endtask

    // Waits until every item has been sent and every result has come back.
    task automatic settle();
        while (op_queue.size() != 0 || req_if.valid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly well-formed traffic on pages that are held, with some noise on top.
    task automatic run_mixed_ops(int n);
        int unsigned roll;
        int unsigned limit;
        int unsigned pick;
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < n; i++) begin
            while (op_queue.size() != 0)
                @(negedge i_clk);
            limit = managed_pages();
            if (held_pages.size() != 0)
                pick = held_pages[$urandom_range(held_pages.size() - 1)];
            else
                pick = $urandom_range(limit == 0 ? 0 : limit - 1);
            roll = $urandom_range(99);
            if (roll < 1) begin
                queue_op(FN_INIT, {$urandom, $urandom});
            end else if (roll < 31) begin
                queue_op(FN_ALLOC, {$urandom, $urandom});
            end else if (roll < 56) begin
                queue_op(FN_ADD_REF, page_at(base_r, pick));
            end else if (roll < 84) begin
                queue_op(FN_DROP_REF, page_at(base_r, pick));
            end else begin
                case ($urandom_range(3))
                    0: addr = {$urandom, $urandom};
                    1: addr = page_at(base_r, $urandom_range(limit + 2)) +
                              ADDR_W'($urandom_range(15));
                    2: addr = base_r - (ADDR_W'($urandom_range(1, 3)) << PAGE_SHIFT);
                    default: addr = page_at(base_r, $urandom_range(limit));
                endcase
                queue_op(t_func'($urandom_range(2)), addr);
            end
        end
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [CFG_DATA_W-1:0] count,
                             logic [CFG_DATA_W-1:0] kept, t_idle_mode mode, int n);
        settle();
        write_reg(CFG_MEM_BASE, base);
        write_reg(CFG_PAGE_COUNT, count);
        write_reg(CFG_RESERVED, kept);
        idle_mode = mode;
        queue_op(FN_INIT, {$urandom, $urandom});
        run_mixed_ops(n);
    endtask

    // Stimulus sequence.
    initial begin
        logic [ADDR_W-1:0] rb;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_MEM_BASE;
        i_cfg_data          = '0;
        req_if.valid        = 1'b0;
        req_if.func         = FN_ALLOC;
        req_if.page_address = '0;
        rsp_if.ready        = 1'b0;
        err_cnt             = 0;
        idle_mode           = IDLE_NONE;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing is managed before the first initialize.
        rb = MEM_BASE_RST;
        queue_op(FN_ADD_REF, rb);
        queue_op(FN_DROP_REF, rb);
        queue_op(FN_ALLOC, '1);
        settle();

        // Three pages, the lowest reserved.
        write_reg(CFG_PAGE_COUNT, 3);
        write_reg(CFG_RESERVED, 1);
        queue_op(FN_INIT, '0);
        queue_op(FN_ALLOC, '0);
        queue_op(FN_ALLOC, '1);
        queue_op(FN_ALLOC, rb);
        queue_op(FN_ADD_REF, page_at(rb, 0));
        queue_op(FN_DROP_REF, page_at(rb, 0));
        queue_op(FN_DROP_REF, page_at(rb, 0));
        queue_op(FN_DROP_REF, page_at(rb, 0));
        queue_op(FN_ADD_REF, page_at(rb, 0));
        queue_op(FN_ADD_REF, rb + 1);
        queue_op(FN_ADD_REF, rb - (ADDR_W'(1) << PAGE_SHIFT));
        queue_op(FN_ADD_REF, page_at(rb, 3));
        queue_op(FN_DROP_REF, '0);
        queue_op(FN_DROP_REF, '1);
        queue_op(FN_ALLOC, '0);
        queue_op(FN_DROP_REF, page_at(rb, 2));
        queue_op(FN_DROP_REF, page_at(rb, 1));
        queue_op(FN_ALLOC, '0);
        queue_op(FN_INIT, '1);
        settle();
        write_reg(CFG_UNUSED, '1);

        // Random phases over a spread of layouts and idling patterns.
        run_phase(MEM_BASE_RST, 64'hFFFF_FFFF_FFFF_E010, 64'hABCD_0000_0000_0002,
                  IDLE_NONE, 150);
        run_phase('0, 1, 0, IDLE_SEND, 120);
        run_phase(64'hFFFF_FFFF_FFFF_E000, 8, 3, IDLE_RECV, 150);
        run_phase({$urandom, $urandom} & ~ADDR_W'(DEF_PAGE_BYTES - 1), 4096, 0,
                  IDLE_BOTH, 200);
        run_phase({$urandom, $urandom}, 0, 7, IDLE_BOTH, 60);
        run_phase({$urandom, $urandom}, 8191, 8191, IDLE_NONE, 60);
        run_phase(64'h0000_0010_0000_0000, 32, 4, IDLE_SEND, 150);

        // Shrink the window and move it without a fresh initialize.
        settle();
        write_reg(CFG_MEM_BASE, 64'h0000_0010_0010_0000);
        write_reg(CFG_PAGE_COUNT, 10);
        idle_mode = IDLE_RECV;
        run_mixed_ops(150);

        // Drive one count up by a run of references, with one drop among them.
        settle();
        write_reg(CFG_MEM_BASE, MEM_BASE_RST);
        write_reg(CFG_PAGE_COUNT, 2);
        write_reg(CFG_RESERVED, 1);
        idle_mode = IDLE_NONE;
        queue_op(FN_INIT, '0);
        repeat (CLIMB_OPS) queue_op(FN_ADD_REF, page_at(MEM_BASE_RST, 0));
        queue_op(FN_DROP_REF, page_at(MEM_BASE_RST, 0));
        queue_op(FN_ADD_REF, page_at(MEM_BASE_RST, 0));
        queue_op(FN_ADD_REF, page_at(MEM_BASE_RST, 0));
        queue_op(FN_ALLOC, '0);
        queue_op(FN_ADD_REF, page_at(MEM_BASE_RST, 1));
        idle_mode = IDLE_BOTH;
        run_mixed_ops(40);

        settle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
